[rtl/daily_slot_alarm_scheduler_macros.svh]
// Assertion macros used by the scheduler top level.
`ifndef DAILY_SLOT_ALARM_SCHEDULER_MACROS_SVH
`define DAILY_SLOT_ALARM_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DSAS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DSAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler next-cycle check failed");

`endif

[rtl/dsas_pkg.sv]
// Shared types and constants of the daily slot alarm scheduler.
package dsas_pkg;

  localparam int SLOT_REGS = 7;
  localparam int SLOT_W    = 3;
  localparam int TIME_W    = 12;
  localparam int QDEPTH    = 4;

  localparam logic [SLOT_W-1:0] NO_SLOT   = 3'd7;
  localparam logic [6:0]        NONE_SEEN = 7'd99;
  localparam logic signed [12:0] DAY_MINUTES = 13'sd1440;

  // event kinds
  localparam logic [1:0] KIND_WARN   = 2'd0;
  localparam logic [1:0] KIND_DISP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MASTER_EN = 3'd0;
  localparam logic [2:0] REG_SLOT0     = 3'd1;

  typedef logic [SLOT_REGS-1:0][TIME_W-1:0] slot_times_t;

  // one classified input, as handed from front to back
  typedef struct packed {
    logic [SLOT_REGS-1:0] warn;
    logic [SLOT_REGS-1:0] disp;
    logic [SLOT_W-1:0]    best;
  } item_t;

endpackage

[rtl/daily_slot_alarm_scheduler.sv]
// Top level of the daily slot alarm scheduler.
//
//  channel   dir  beat carries
//  s_axis    in   tdata: hour_now, minute_now
//  m_axis    out  tdata: event_kind, slot_index, next_slot; tlast: last
//  cfg       in   write: register index, data (no read-back)
//
// Each time beat yields 1 to 8 result beats: one per warning or dispense,
// then one status beat with tlast. The back end sends one beat a cycle
// unless the output stalls; the front end takes a beat every cycle while
// its 4-entry queue has room. Beats pass stage A, the queue and the back
// end's item and output registers. Reset (sync, high) restores the register
// defaults, clears the per-slot flags and sets the last minute to none.
// Either side may stall freely; the queue and output register absorb it.
`include "daily_slot_alarm_scheduler_macros.svh"

module daily_slot_alarm_scheduler #(
  parameter int NUM_SLOTS         = 7,
  parameter int WARN_LEAD_MINUTES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [4:0] hour_now, [10:5] minute_now, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] event_kind, [4:2] slot_index, [7:5] next_slot
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  import dsas_pkg::*;

  localparam int N_ACT = (NUM_SLOTS < SLOT_REGS) ? NUM_SLOTS : SLOT_REGS;

  // config registers
  logic        master_enable;
  slot_times_t slot_time;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_wr;
  item_t q_rd;

  logic [1:0] out_kind;
  logic [2:0] out_slot;
  logic [2:0] out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_enable <= 1'b1;
      slot_time[0]  <= 12'd2560;  // 08:00
      slot_time[1]  <= 12'd2590;  // 08:30
      slot_time[2]  <= 12'd2816;  // 12:00
      slot_time[3]  <= 12'd2846;  // 12:30
      slot_time[4]  <= 12'd3136;  // 17:00
      slot_time[5]  <= 12'd3166;  // 17:30
      slot_time[6]  <= 12'd3392;  // 21:00
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_MASTER_EN) begin
        master_enable <= cfg_wdata[0];
      end else begin
        slot_time[cfg_index - REG_SLOT0] <= cfg_wdata;
      end
    end
  end

  dsas_front #(
    .NUM_SLOTS         (NUM_SLOTS),
    .WARN_LEAD_MINUTES (WARN_LEAD_MINUTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .master_enable (master_enable),
    .slot_time     (slot_time),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_hour       (s_axis_tdata[4:0]),
    .in_minute     (s_axis_tdata[10:5]),
    .push          (q_push),
    .push_item     (q_wr),
    .q_full        (q_full)
  );

  dsas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_item  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_rd)
  );

  dsas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_rd),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (out_kind),
    .out_slot  (out_slot),
    .out_next  (out_next),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_next, out_slot, out_kind};

  // tlast marks exactly the status beat
  `DSAS_ASSERT_IMPL(a_last_is_status, m_axis_tvalid,
    m_axis_tlast == (out_kind == KIND_STATUS))
  // event beats name an existing slot and carry no next slot
  `DSAS_ASSERT_IMPL(a_event_fields, m_axis_tvalid && (out_kind != KIND_STATUS),
    (out_next == 3'd0) && (32'(out_slot) < N_ACT))
  // status beats carry slot 0 and a real slot or none
  `DSAS_ASSERT_IMPL(a_status_fields, m_axis_tvalid && (out_kind == KIND_STATUS),
    (out_slot == 3'd0) && ((out_next == NO_SLOT) || (32'(out_next) < N_ACT)))
  // a stalled queue-full front end cannot take a beat
  `DSAS_ASSERT_NEXT(a_full_pops_first, q_full && !q_pop, !q_push || q_full)

endmodule

[rtl/dsas_queue.sv]
// Small FIFO of classified items between front and back.
module dsas_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dsas_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output dsas_pkg::item_t rd_item
);
  import dsas_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  item_t             mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full     = (count == (PTR_W+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/dsas_front.sv]
// Front end: takes time beats, tracks flags, classifies slots per input.
module dsas_front #(
  parameter int NUM_SLOTS         = 7,
  parameter int WARN_LEAD_MINUTES = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  master_enable,
  input  dsas_pkg::slot_times_t slot_time,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [4:0]            in_hour,
  input  logic [5:0]            in_minute,
  output logic                  push,
  output dsas_pkg::item_t       push_item,
  input  logic                  q_full
);
  import dsas_pkg::*;

  localparam int N_ACT = (NUM_SLOTS < SLOT_REGS) ? NUM_SLOTS : SLOT_REGS;
  localparam logic signed [12:0] WARN_LEAD = 13'(WARN_LEAD_MINUTES);

  // stage A registers
  logic        a_valid;
  logic        a_active;
  logic        a_mid;
  logic [4:0]  a_hour;
  logic [5:0]  a_minute;
  logic [10:0] a_now;

  logic [6:0]           last_minute;
  logic [SLOT_REGS-1:0] warned;
  logic [SLOT_REGS-1:0] dispensed;

  logic                 accept;
  logic                 in_active;
  logic [10:0]          in_now;

  logic [SLOT_REGS-1:0] en;
  logic [SLOT_REGS-1:0] warn_hit;
  logic [SLOT_REGS-1:0] disp_hit;
  logic signed [12:0]   ahead [SLOT_REGS];
  logic [SLOT_REGS-1:0] warned_base;
  logic [SLOT_REGS-1:0] disp_base;
  logic [SLOT_REGS-1:0] warn_emit;
  logic [SLOT_REGS-1:0] disp_emit;
  logic [SLOT_W-1:0]    best;

  assign push     = a_valid && !q_full;
  assign in_ready = !a_valid || !q_full;
  assign accept   = in_valid && in_ready;

  assign in_active = master_enable && ({1'b0, in_minute} != last_minute);
  // hour*60 as hour*64 - hour*4
  assign in_now = {in_hour, 6'd0} - {4'd0, in_hour, 2'd0} + {5'd0, in_minute};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      last_minute <= NONE_SEEN;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (in_active) begin
          last_minute <= {1'b0, in_minute};
        end
      end else if (push) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_active <= in_active;
      a_mid    <= (in_hour == 5'd0) && (in_minute == 6'd0);
      a_hour   <= in_hour;
      a_minute <= in_minute;
      a_now    <= in_now;
    end
  end

  // per-slot lanes
  always_comb begin
    logic [10:0]        s_mod;
    logic signed [12:0] diff;
    logic signed [12:0] diff_w;
    for (int i = 0; i < SLOT_REGS; i++) begin
      en[i]  = slot_time[i][11] && (i < N_ACT);
      s_mod  = {slot_time[i][10:6], 6'd0} - {4'd0, slot_time[i][10:6], 2'd0}
             + {5'd0, slot_time[i][5:0]};
      diff   = $signed({2'b00, s_mod}) - $signed({2'b00, a_now});
      diff_w = (diff < 0) ? diff + DAY_MINUTES : diff;
      ahead[i] = (diff <= 0) ? diff + DAY_MINUTES : diff;
      warn_hit[i] = en[i] && (diff_w == WARN_LEAD);
      disp_hit[i] = en[i] && (slot_time[i][10:6] == a_hour)
                  && (slot_time[i][5:0] == a_minute);
    end
  end

  // nearest enabled slot strictly ahead; lowest index wins ties
  always_comb begin
    logic               found;
    logic signed [12:0] bd;
    found = 1'b0;
    bd    = '0;
    best  = NO_SLOT;
    for (int i = 0; i < SLOT_REGS; i++) begin
      if (en[i] && (!found || ahead[i] < bd)) begin
        found = 1'b1;
        bd    = ahead[i];
        best  = SLOT_W'(i);
      end
    end
  end

  assign warned_base = a_mid ? '0 : warned;
  assign disp_base   = a_mid ? '0 : dispensed;
  assign warn_emit   = a_active ? (warn_hit & ~warned_base) : '0;
  assign disp_emit   = a_active ? (disp_hit & ~disp_base) : '0;

  assign push_item.warn = warn_emit;
  assign push_item.disp = disp_emit;
  assign push_item.best = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      warned    <= '0;
      dispensed <= '0;
    end else if (push && a_active) begin
      warned    <= warned_base | warn_emit | disp_emit;
      dispensed <= disp_base | disp_emit;
    end
  end

endmodule

[rtl/dsas_back.sv]
// Back end: serializes one classified item into event beats and a status beat.
module dsas_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  dsas_pkg::item_t   q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [2:0]        out_slot,
  output logic [2:0]        out_next,
  output logic              out_last
);
  import dsas_pkg::*;

  localparam int EV_W  = 2 * SLOT_REGS;
  localparam int POS_W = $clog2(EV_W);

  logic  cur_valid;
  item_t cur;

  logic [EV_W-1:0]  ev;
  logic [EV_W-1:0]  ev_one;
  logic [EV_W-1:0]  ev_left;
  logic [POS_W-1:0] pos;
  logic             ev_any;
  logic             out_free;
  logic             step;
  logic             finish;

  // warn of slot i at bit 2i, dispense at 2i+1: index order, warn first
  always_comb begin
    for (int j = 0; j < SLOT_REGS; j++) begin
      ev[2*j]   = cur.warn[j];
      ev[2*j+1] = cur.disp[j];
    end
  end

  assign ev_any  = |ev;
  assign ev_one  = ev & (~ev + 1'b1);
  assign ev_left = ev & ~ev_one;

  always_comb begin
    pos = '0;
    for (int j = 0; j < EV_W; j++) begin
      if (ev_one[j]) begin
        pos = pos | POS_W'(j);
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign step     = cur_valid && out_free;
  assign finish   = step && !ev_any;
  assign pop      = q_valid && (!cur_valid || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end else if (step && ev_any) begin
      for (int j = 0; j < SLOT_REGS; j++) begin
        cur.warn[j] <= ev_left[2*j];
        cur.disp[j] <= ev_left[2*j+1];
      end
    end
    if (step) begin
      if (ev_any) begin
        out_kind <= pos[0] ? KIND_DISP : KIND_WARN;
        out_slot <= pos[POS_W-1:1];
        out_next <= '0;
        out_last <= 1'b0;
      end else begin
        out_kind <= KIND_STATUS;
        out_slot <= '0;
        out_next <= cur.best;
        out_last <= 1'b1;
      end
    end
  end

endmodule
